@@ rtl/u8v_pkg.sv @@
`default_nettype none
package u8v_pkg;

  // default depth of the queue between classifier and checker
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] EdLead    = 8'hed;
  localparam logic [7:0] SurrMask  = 8'ha0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;

  // classified byte, as it travels from front to back
  typedef struct packed {
    logic [1:0] lead_len;  // continuations a lead byte calls for
    logic       lead_bad;  // byte is no legal lead
    logic       cont_ok;   // byte matches 10xxxxxx
    logic       is_ed;     // byte is the 0xed lead
    logic       surr_bits; // (b & 0xa0) == 0xa0
    logic       last;      // closes the string
  } beat_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic beat_t classify(input logic [7:0] b, input logic last);
    beat_t r;
    r.lead_len  = 2'd0;
    r.lead_bad  = 1'b0;
    if (b <= AsciiMax) begin
      r.lead_len = 2'd0;
    end else if ((b & Lead2Mask) == Lead2Code) begin
      r.lead_len = 2'd1;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      r.lead_len = 2'd2;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      r.lead_len = 2'd3;
    end else begin
      r.lead_bad = 1'b1;
    end
    r.cont_ok   = ((b & ContMask) == ContCode);
    r.is_ed     = (b == EdLead);
    r.surr_bits = ((b & SurrMask) == SurrMask);
    r.last      = last;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_stream_validator.sv @@
// a byte's result passes the front register, a queue entry and the back's output register before it is offered
// throughput: one byte per cycle, sustained while the result side keeps taking
// the one-cycle figure is set by the checker's decode step, a short 4-bit state loop
// reset: rst_ni low clears the decode state, the queue and all valid flags at once
// after reset the block takes a byte in the first cycle
`default_nettype none
module utf8_stream_validator #(
  parameter int unsigned QueueDepth = u8v_pkg::QueueDepth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [7:0]  data_byte_i,
  input  wire        last_byte_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       error_so_far_o,
  output logic       string_done_o,
  output logic       string_valid_o
);

  // front to queue
  logic             push;
  u8v_pkg::beat_t   push_beat;
  // queue to back
  u8v_pkg::beat_t   pop_beat;
  u8v_pkg::q_stat_t q_stat;
  logic             back_ready;

  // front: registers each byte already classified (lead length, continuation
  // pattern, 0xed lead, surrogate bits), so the back never looks at raw bytes
  u8v_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .beat_o      (push_beat)
  );

  // short queue so a stalled result side does not stall the front at once
  u8v_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (push_beat),
    .pop_i       (back_ready),
    .pop_beat_o  (pop_beat),
    .stat_o      (q_stat)
  );

  // back: decode state (pending continuations, 0xed flag, sticky error)
  // and the output register; state clears after the string's last beat
  u8v_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_valid_i   (!q_stat.empty),
    .beat_ready_o   (back_ready),
    .beat_i         (pop_beat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .error_so_far_o (error_so_far_o),
    .string_done_o  (string_done_o),
    .string_valid_o (string_valid_o)
  );

`ifndef NO_ASSERTIONS
  // a valid string is always a closed string with no error
  a_valid_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_valid_o |-> string_done_o && !error_so_far_o)
    else $error("string_valid without done or with error");

  // queue cannot be full and empty at once
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({q_stat.full, q_stat.empty}))
    else $error("queue status inconsistent");

  // front only stalls input when the queue is full
  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_stat.full)
    else $error("input stalled while queue has room");

  // a full queue drains one beat when the back takes one
  a_queue_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full && back_ready && !push |=> !q_stat.full)
    else $error("queue failed to drain");
`endif

endmodule
`default_nettype wire

@@ rtl/u8v_front.sv @@
`default_nettype none
module u8v_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [7:0]           data_byte_i,
  input  wire                 last_byte_i,
  input  u8v_pkg::q_stat_t    q_stat_i,
  output logic                push_o,
  output u8v_pkg::beat_t      beat_o
);

  logic           valid_q, valid_d;
  u8v_pkg::beat_t beat_q;

  assign push_o     = valid_q && !q_stat_i.full;
  assign in_ready_o = !valid_q || !q_stat_i.full;
  assign beat_o     = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= u8v_pkg::classify(data_byte_i, last_byte_i);
    end
  end

endmodule
`default_nettype wire

@@ rtl/u8v_fifo.sv @@
`default_nettype none
module u8v_fifo #(
  parameter int unsigned Depth = u8v_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  u8v_pkg::beat_t      push_beat_i,
  input  wire                 pop_i,
  output u8v_pkg::beat_t      pop_beat_o,
  output u8v_pkg::q_stat_t    stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8v_pkg::beat_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_beat_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/u8v_back.sv @@
`default_nettype none
module u8v_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 beat_valid_i,
  output logic                beat_ready_o,
  input  u8v_pkg::beat_t      beat_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                error_so_far_o,
  output logic                string_done_o,
  output logic                string_valid_o
);

  logic [1:0] cont_q, cont_d;
  logic       ed_q, ed_d;
  logic       err_q, err_d;
  logic       out_valid_q;
  logic       err_out_q, done_q, str_valid_q;
  logic       take;
  logic       surrogate;

  assign beat_ready_o   = !out_valid_q || out_ready_i;
  assign take           = beat_valid_i && beat_ready_o;
  assign out_valid_o    = out_valid_q;
  assign error_so_far_o = err_out_q;
  assign string_done_o  = done_q;
  assign string_valid_o = str_valid_q;
  assign surrogate      = ed_q && beat_i.surr_bits;

  // decode step for one byte
  always_comb begin
    cont_d = cont_q;
    ed_d   = ed_q;
    err_d  = err_q;
    if (err_q) begin
      cont_d = 2'd0;
      ed_d   = 1'b0;
    end else if (cont_q != 2'd0) begin
      ed_d = 1'b0;
      if (surrogate || !beat_i.cont_ok) begin
        err_d  = 1'b1;
        cont_d = 2'd0;
      end else begin
        cont_d = cont_q - 2'd1;
      end
    end else if (beat_i.lead_bad) begin
      err_d = 1'b1;
      ed_d  = 1'b0;
    end else begin
      cont_d = beat_i.lead_len;
      ed_d   = beat_i.is_ed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q      <= 2'd0;
      ed_q        <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      err_out_q   <= 1'b0;
      done_q      <= 1'b0;
      str_valid_q <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        err_out_q   <= err_d;
        done_q      <= beat_i.last;
        str_valid_q <= beat_i.last && !err_d && (cont_d == 2'd0);
        if (beat_i.last) begin
          cont_q <= 2'd0;
          ed_q   <= 1'b0;
          err_q  <= 1'b0;
        end else begin
          cont_q <= cont_d;
          ed_q   <= ed_d;
          err_q  <= err_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ test/tb_utf8_stream_validator.sv @@
`default_nettype none
module tb_utf8_stream_validator;
  timeunit 1ns;
  timeprecision 1ps;

  // run-away guard, far above the slowest legal run
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 850;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DirRows    = 24;

  // what one result beat should carry
  typedef struct packed {
    logic err;
    logic done;
    logic ok;
  } verdict_t;

  // one row of the directed table; known rows carry a hand-written verdict
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       known;
    logic       err;
    logic       done;
    logic       ok;
  } dir_row_t;

  typedef enum int unsigned {ShapeGood, ShapeBroken, ShapeNoise} shape_e;
  typedef enum int unsigned {CharAscii, Char2, Char3, Char4, CharEd} char_kind_e;
  typedef enum int unsigned {FaultTrunc, FaultBadCont, FaultSurr} fault_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       error_so_far_o;
  logic       string_done_o;
  logic       string_valid_o;

  // predictor state: pending continuations, previous byte was the 0xed lead, sticky error
  logic [1:0] pend_cont;
  logic       ed_seen;
  logic       err_seen;

  verdict_t    verdict_q[$];
  int unsigned bytes_sent;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          quiet;     // no idling on either side
  bit          hold_req;  // ask the receiver for one long hold-off

  // byte, last, known, err, done, ok
  dir_row_t dir_rows [DirRows] = '{
    '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1},  // lowest ascii
    '{8'h7f, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1},  // highest ascii
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},  // stray continuation as lead
    '{8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},  // highest byte, no legal lead
    '{8'hf8, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},  // first illegal lead above four-byte range
    '{8'hc0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},  // overlong two-byte form is accepted
    '{8'h80, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1},
    '{8'hdf, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hed, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},  // surrogate after 0xed lead
    '{8'ha0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hed, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},  // highest non-surrogate after 0xed
    '{8'h9f, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hf7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},  // above the top code point, still accepted
    '{8'hbf, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'he0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},  // string ends short, no error flag
    '{8'hc2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},  // continuation that is not 10xxxxxx
    '{8'h41, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hfe, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},  // bytes after an error are not decoded
    '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hc2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  utf8_stream_validator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .error_so_far_o (error_so_far_o),
    .string_done_o  (string_done_o),
    .string_valid_o (string_valid_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // advance the decoder by one byte and return the verdict it should produce
  function automatic verdict_t predict_verdict(input logic [7:0] b, input logic l);
    verdict_t   v;
    logic [1:0] need;
    logic       bad;
    need = 2'd0;
    bad  = 1'b0;
    if (err_seen) begin
      // poisoned string: nothing is decoded until its last byte
      pend_cont = 2'd0;
      ed_seen   = 1'b0;
    end else if (pend_cont != 2'd0) begin
      // surrogate range after 0xed has bits 7 and 5 both set
      if ((ed_seen && b[7] && b[5]) || b[7:6] != 2'b10) begin
        err_seen  = 1'b1;
        pend_cont = 2'd0;
      end else begin
        pend_cont = pend_cont - 2'd1;
      end
      ed_seen = 1'b0;
    end else begin
      casez (b)
        8'b0???????: need = 2'd0;
        8'b110?????: need = 2'd1;
        8'b1110????: need = 2'd2;
        8'b11110???: need = 2'd3;
        default:     bad  = 1'b1;
      endcase
      if (bad) begin
        err_seen = 1'b1;
        ed_seen  = 1'b0;
      end else begin
        pend_cont = need;
        ed_seen   = (b == u8v_pkg::EdLead);
      end
    end
    v.err  = err_seen;
    v.done = l;
    v.ok   = l && !err_seen && (pend_cont == 2'd0);
    if (l) begin
      pend_cont = 2'd0;
      ed_seen   = 1'b0;
      err_seen  = 1'b0;
    end
    return v;
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // offer one beat, hold it until taken, then queue its verdict
  task automatic send_beat(input logic [7:0] b, input logic l, input bit known,
                           input verdict_t hand);
    verdict_t v;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    v = predict_verdict(b, l);
    verdict_q.push_back(known ? hand : v);
    bytes_sent++;
  endtask

  // sender goes quiet until every queued verdict has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // append one well-formed character of a random kind
  task automatic push_char(ref logic [7:0] s[$]);
    char_kind_e k;
    logic [7:0] lead;
    k = char_kind_e'($urandom_range(0, 4));
    case (k)
      CharAscii: s.push_back(8'($urandom_range(8'h00, 8'h7f)));
      Char2: begin
        s.push_back(8'($urandom_range(8'hc0, 8'hdf)));
        s.push_back(rand_cont());
      end
      Char3, CharEd: begin
        lead = (k == CharEd) ? u8v_pkg::EdLead : 8'($urandom_range(8'he0, 8'hef));
        s.push_back(lead);
        // keep 0xed out of the surrogate range here
        s.push_back((lead == u8v_pkg::EdLead) ? 8'h80 | 8'($urandom_range(0, 31))
                                               : rand_cont());
        s.push_back(rand_cont());
      end
      default: begin
        s.push_back(8'($urandom_range(8'hf0, 8'hf7)));
        repeat (3) s.push_back(rand_cont());
      end
    endcase
  endtask

  task automatic build_string(ref logic [7:0] s[$]);
    int unsigned r;
    shape_e      shape;
    fault_e      f;
    int unsigned pos;
    s.delete();
    r = $urandom_range(0, 9);
    shape = (r < 7) ? ShapeGood : (r < 9) ? ShapeBroken : ShapeNoise;
    if (shape == ShapeNoise) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom()));
    end else begin
      repeat ($urandom_range(1, 6)) push_char(s);
      if (shape == ShapeBroken) begin
        f = fault_e'($urandom_range(0, 2));
        case (f)
          FaultTrunc: begin
            // multibyte lead at the end with none or one continuation, too few unless a two-byte lead gets its one
            s.push_back(8'($urandom_range(8'hc0, 8'hf7)));
            repeat ($urandom_range(0, 1)) s.push_back(rand_cont());
          end
          FaultBadCont: begin
            pos = $urandom_range(0, s.size() - 1);
            s[pos] = 8'($urandom());
            repeat ($urandom_range(0, 2)) push_char(s);
          end
          default: begin
            s.push_back(u8v_pkg::EdLead);
            s.push_back(8'ha0 | 8'($urandom_range(0, 31)));
            repeat ($urandom_range(0, 2)) push_char(s);
          end
        endcase
      end
    end
  endtask

  // result side: compare every taken beat with the oldest verdict
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no verdict pending");
        fail_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (error_so_far_o !== exp_v.err) begin
          $error("error_so_far: expected %0b, got %0b", exp_v.err, error_so_far_o);
          fail_cnt++;
        end
        if (string_done_o !== exp_v.done) begin
          $error("string_done: expected %0b, got %0b", exp_v.done, string_done_o);
          fail_cnt++;
        end
        if (string_valid_o !== exp_v.ok) begin
          $error("string_valid: expected %0b, got %0b", exp_v.ok, string_valid_o);
          fail_cnt++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request, none in the quiet tail
  initial begin
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // stretches of steady ready now and then
      repeat ((!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : 1)
        @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0]  str[$];
    verdict_t    hand;
    bit          hold_done;
    bit          drain_done;
    int unsigned rand_end;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    pend_cont   = 2'd0;
    ed_seen     = 1'b0;
    err_seen    = 1'b0;
    bytes_sent  = 0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    drain_done  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      hand = '{dir_rows[i].err, dir_rows[i].done, dir_rows[i].ok};
      send_beat(dir_rows[i].b, dir_rows[i].l, dir_rows[i].known, hand);
    end

    // random strings, mostly well-formed
    rand_end = bytes_sent + RandBytes;
    while (bytes_sent < rand_end) begin
      if (!hold_done && bytes_sent > rand_end - RandBytes + 250) begin
        // receiver stalls while bytes keep coming, so the input side backs up
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && bytes_sent > rand_end - RandBytes + 500) begin
        drain_results();
        drain_done = 1'b1;
      end
      quiet = (bytes_sent > rand_end - 100);
      build_string(str);
      foreach (str[j]) send_beat(str[j], j == str.size() - 1, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    // room for any stray late beat
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ utf8_stream_validator.f @@
rtl/u8v_pkg.sv
rtl/u8v_front.sv
rtl/u8v_fifo.sv
rtl/u8v_back.sv
rtl/utf8_stream_validator.sv
test/tb_utf8_stream_validator.sv
